// ===== src/ftpc_pkg.sv =====
package ftpc_pkg;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_TICK_PERIOD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_MINUTES = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DUTY_STEP   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DUTY_MAX    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DUTY_MIN    = 3'd4;

    localparam logic [15:0] RST_TICK_PERIOD = 16'd1000;
    localparam logic [5:0]  RST_MAX_MINUTES = 6'd5;
    localparam logic [6:0]  RST_DUTY_STEP   = 7'd10;
    localparam logic [6:0]  RST_DUTY_MAX    = 7'd100;
    localparam logic [6:0]  RST_DUTY_MIN    = 7'd70;

    localparam logic [5:0]  SEC_WRAP      = 6'd59;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [15:0] MS_SAT        = 16'hFFFF;

    localparam logic [1:0] MODE_STOPPED = 2'd0;
    localparam logic [1:0] MODE_RUNNING = 2'd1;
    localparam logic [1:0] MODE_SETTING = 2'd2;

    typedef struct packed {
        logic [15:0] tick_period;
        logic [5:0]  max_minutes;
        logic [6:0]  duty_step;
        logic [6:0]  duty_max;
        logic [6:0]  duty_min;
    } t_cfg;

    typedef struct packed {
        logic tick;
        logic press_start;
        logic press_up;
        logic press_down;
        logic press_set;
    } t_poll;

    typedef struct packed {
        logic        stopped;
        logic        in_setting;
        logic [11:0] remaining;
        logic [15:0] ms_count;
        logic [5:0]  edit_minutes;
        logic [5:0]  edit_seconds;
        logic [6:0]  duty;
    } t_state;

endpackage

// ===== src/fan_timer_pwm_controller_top.sv =====
// channel | valid        | stall        | payload
// poll in | i_in_valid   | o_in_stall   | i_tick, i_press_start/up/down/set
// result  | o_out_valid  | i_out_stall  | o_motor_on, o_duty_level, o_seconds_left,
//         |              |              | o_mode, o_set_minutes, o_set_seconds
// config  | i_cfg_we     | none         | i_cfg_addr, i_cfg_wdata
// One poll per clock unless stalled; its result enters the output register at transfer.
// The state update is one combinational pass; the state register also holds the result.
// Reset is synchronous, active low; resets state and config and clears the result valid.
// A stalled result blocks the input only while it is held; a taken result frees the slot
// in the same cycle.
module fan_timer_pwm_controller_top
    import ftpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_tick,
    input  logic                  i_press_start,
    input  logic                  i_press_up,
    input  logic                  i_press_down,
    input  logic                  i_press_set,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_motor_on,
    output logic [6:0]            o_duty_level,
    output logic [11:0]           o_seconds_left,
    output logic [1:0]            o_mode,
    output logic [5:0]            o_set_minutes,
    output logic [5:0]            o_set_seconds
);

    t_cfg   cfg;
    t_poll  poll;
    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   in_xfer;

    ftpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign poll = '{tick: i_tick, press_start: i_press_start, press_up: i_press_up,
                    press_down: i_press_down, press_set: i_press_set};

    ftpc_step u_step (
        .i_cfg   (cfg),
        .i_poll  (poll),
        .i_state (r_state),
        .o_state (n_state)
    );

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.stopped      <= 1'b0;
            r_state.in_setting   <= 1'b0;
            r_state.remaining    <= 12'd0;
            r_state.ms_count     <= 16'd0;
            r_state.edit_minutes <= 6'd0;
            r_state.edit_seconds <= 6'd0;
            r_state.duty         <= RST_DUTY_MAX;
            r_out_valid          <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result fields mirror the state captured at the last transfer
    assign o_out_valid    = r_out_valid;
    assign o_motor_on     = !r_state.stopped;
    assign o_duty_level   = r_state.duty;
    assign o_seconds_left = r_state.remaining;
    assign o_mode         = r_state.in_setting ? MODE_SETTING
                          : (r_state.stopped ? MODE_STOPPED : MODE_RUNNING);
    assign o_set_minutes  = r_state.edit_minutes;
    assign o_set_seconds  = r_state.edit_seconds;

    a_stall_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_xfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_out_valid)
        else $error("accepted poll produced no result");

    a_motor_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_motor_on == (o_mode == MODE_RUNNING)))
        else $error("motor state disagrees with mode");

    a_setting_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && n_state.in_setting) |-> n_state.stopped)
        else $error("setting entered while running");

endmodule

// ===== src/ftpc_cfg.sv =====
module ftpc_cfg
    import ftpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_period <= RST_TICK_PERIOD;
            r_cfg.max_minutes <= RST_MAX_MINUTES;
            r_cfg.duty_step   <= RST_DUTY_STEP;
            r_cfg.duty_max    <= RST_DUTY_MAX;
            r_cfg.duty_min    <= RST_DUTY_MIN;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_TICK_PERIOD: r_cfg.tick_period <= i_cfg_wdata;
                REG_MAX_MINUTES: r_cfg.max_minutes <= i_cfg_wdata[5:0];
                REG_DUTY_STEP:   r_cfg.duty_step   <= i_cfg_wdata[6:0];
                REG_DUTY_MAX:    r_cfg.duty_max    <= i_cfg_wdata[6:0];
                REG_DUTY_MIN:    r_cfg.duty_min    <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/ftpc_step.sv =====
module ftpc_step
    import ftpc_pkg::*;
(
    input  t_cfg   i_cfg,
    input  t_poll  i_poll,
    input  t_state i_state,
    output t_state o_state
);

    function automatic logic [5:0] inc_minutes(input logic [5:0] m, input logic [5:0] mx);
        logic [5:0] m1;
        m1 = m + 6'd1;
        return (m1 > mx) ? 6'd0 : m1;
    endfunction

    function automatic logic [5:0] inc_seconds(input logic [5:0] s);
        return (s >= SEC_WRAP) ? 6'd0 : s + 6'd1;
    endfunction

    logic [5:0]  min_edit;
    logic [5:0]  sec_edit;
    logic [5:0]  min_fresh;
    logic [5:0]  sec_fresh;
    logic [15:0] ms_inc;
    logic [11:0] load_time;
    logic        stp;
    logic [7:0]  duty_sum;
    logic [6:0]  duty_up;
    logic [6:0]  duty_dn;
    t_state      n_state;

    always_comb begin
        min_edit  = i_poll.press_start ? inc_minutes(i_state.edit_minutes, i_cfg.max_minutes)
                                       : i_state.edit_minutes;
        sec_edit  = i_poll.press_up ? inc_seconds(i_state.edit_seconds) : i_state.edit_seconds;
        min_fresh = i_poll.press_start ? inc_minutes(6'd0, i_cfg.max_minutes) : 6'd0;
        sec_fresh = i_poll.press_up ? inc_seconds(6'd0) : 6'd0;
        ms_inc    = (i_poll.tick && i_state.ms_count != MS_SAT) ? i_state.ms_count + 16'd1
                                                                 : i_state.ms_count;
        load_time = ({6'd0, min_edit} * {6'd0, SECS_PER_MIN}) + {6'd0, sec_edit};
        stp       = i_state.stopped || (i_state.remaining == 12'd0);

        duty_sum  = {1'b0, i_state.duty} + {1'b0, i_cfg.duty_step};
        duty_up   = i_poll.press_up
                  ? ((duty_sum > {1'b0, i_cfg.duty_max}) ? i_cfg.duty_max : duty_sum[6:0])
                  : i_state.duty;
        if (duty_up < i_cfg.duty_step || (duty_up - i_cfg.duty_step) < i_cfg.duty_min) begin
            duty_dn = i_cfg.duty_min;
        end else begin
            duty_dn = duty_up - i_cfg.duty_step;
        end

        n_state          = i_state;
        n_state.ms_count = ms_inc;
        if (i_state.in_setting) begin
            n_state.edit_minutes = min_edit;
            n_state.edit_seconds = sec_edit;
            if (i_poll.press_set) begin
                n_state.remaining  = load_time;
                n_state.in_setting = 1'b0;
            end
        end else begin
            n_state.stopped = stp;
            if (!stp && ms_inc >= i_cfg.tick_period) begin
                n_state.ms_count = 16'd0;
                if (i_state.remaining != 12'd0) begin
                    n_state.remaining = i_state.remaining - 12'd1;
                end
            end
            if (stp && i_poll.press_set) begin
                n_state.edit_minutes = min_fresh;
                n_state.edit_seconds = sec_fresh;
                n_state.in_setting   = 1'b1;
            end else begin
                if (i_poll.press_start) begin
                    n_state.stopped = !stp;
                end
                n_state.duty = i_poll.press_down ? duty_dn : duty_up;
            end
        end
        o_state = n_state;
    end

endmodule
